@@ design/erle_pkg.sv @@
// ----------------------------------------------------------------------------
// erle_pkg
// Shared types and constants for the escape run-length frame fill decoder.
// ----------------------------------------------------------------------------
package erle_pkg;

  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int ROW_BYTES    = FRAME_WIDTH / 8;
  localparam int FRAME_BYTES  = (ROW_BYTES * FRAME_HEIGHT == 0) ? 1 : ROW_BYTES * FRAME_HEIGHT;

  localparam int POS_W   = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int COUNT_W = 15;
  localparam int CALC_W  = ((POS_W + 1) > (COUNT_W + 1)) ? (POS_W + 1) : (COUNT_W + 1);

  localparam int MAX_RESULTS = 33;
  localparam int SEGNUM_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] ESC_BLACK  = 8'h55;
  localparam logic [7:0] ESC_WHITE  = 8'hAA;
  localparam logic [7:0] FILL_BLACK = 8'h00;
  localparam logic [7:0] FILL_WHITE = 8'hFF;

  typedef struct packed {
    logic [7:0] rle_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0]  fill_byte;
    logic [9:0]  start_index;
    logic [10:0] byte_count;
    logic        frame_done;
    logic        last;
  } out_t;

  // One decoded run handed from the front to the back.
  typedef struct packed {
    logic               restart;
    logic [7:0]         fill;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

@@ design/escape_rle_frame_fill_decoder.sv @@
// ----------------------------------------------------------------------------
// escape_rle_frame_fill_decoder
// Decodes escape run-length coded bytes into frame fill segments.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item) takes one coded byte per beat,
// with a restart flag that clears the decoder and frame position first.
// Output channel (out_valid / out_stall / out_item) delivers one fill segment
// per beat: fill byte, start position, byte count, frame-done and last flags.
// A front stage decodes escapes and counts into run commands and pushes them
// into a two-entry command queue; a back stage pops one run and emits one
// segment per cycle while the output is free, splitting at the frame end.
// A plain byte passes the command queue, the back-stage pop into S_RUN and the
// output register before out_valid rises. The back stage pops a run in S_IDLE
// and emits all its segments in S_RUN before it pops the next run; escape and
// long-count low bytes are handled in the front only.
// When the receiver stalls, the output register holds its beat, the back
// stage waits, the queue fills and in_stall rises once it holds two runs.
// Reset clears the decoder phase, the queue and the position to top left.
// ----------------------------------------------------------------------------
module escape_rle_frame_fill_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  erle_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output erle_pkg::out_t out_item
);
  import erle_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  erle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  erle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  erle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ design/erle_front.sv @@
// ----------------------------------------------------------------------------
// erle_front
// Accepts coded bytes, tracks the escape phase and emits run commands.
// ----------------------------------------------------------------------------
module erle_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  erle_pkg::in_t  in_item,
  input  logic           q_full,
  output logic           q_push,
  output erle_pkg::cmd_t q_cmd
);
  import erle_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_LONG
  } phase_t;

  phase_t     phase;
  logic       run_color;
  logic [6:0] run_low_bits;

  phase_t     phase_eff;
  phase_t     phase_next;
  logic       color_eff;
  logic       color_next;
  logic [6:0] low_eff;
  logic [6:0] low_next;
  logic       accept;
  logic [7:0] run_fill;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    // restart clears the decoder before this byte
    phase_eff  = in_item.restart ? PH_IDLE : phase;
    color_eff  = in_item.restart ? 1'b0 : run_color;
    low_eff    = in_item.restart ? 7'd0 : run_low_bits;
    run_fill   = color_eff ? FILL_WHITE : FILL_BLACK;
    phase_next = PH_IDLE;
    color_next = color_eff;
    low_next   = low_eff;
    q_cmd.restart = in_item.restart;
    q_cmd.fill    = in_item.rle_byte;
    q_cmd.count   = '0;
    case (phase_eff)
      PH_ESC: begin
        if (in_item.rle_byte == 8'd0) begin
          q_cmd.fill  = color_eff ? ESC_WHITE : ESC_BLACK;
          q_cmd.count = COUNT_W'(1);
        end else if (!in_item.rle_byte[7]) begin
          q_cmd.fill  = run_fill;
          q_cmd.count = COUNT_W'(in_item.rle_byte);
        end else begin
          low_next   = in_item.rle_byte[6:0];
          phase_next = PH_LONG;
        end
      end
      PH_LONG: begin
        q_cmd.fill  = run_fill;
        q_cmd.count = {in_item.rle_byte, low_eff};
        low_next    = 7'd0;
      end
      default: begin
        if (in_item.rle_byte inside {ESC_BLACK, ESC_WHITE}) begin
          color_next = (in_item.rle_byte == ESC_WHITE);
          phase_next = PH_ESC;
        end else begin
          q_cmd.count = COUNT_W'(1);
        end
      end
    endcase
  end

  // forward a bare restart too, so the back clears the position in order
  assign q_push = accept && ((q_cmd.count != '0) || in_item.restart);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      run_color    <= 1'b0;
      run_low_bits <= 7'd0;
    end else if (accept) begin
      phase        <= phase_next;
      run_color    <= color_next;
      run_low_bits <= low_next;
    end
  end

endmodule

@@ design/erle_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// erle_cmd_fifo
// Two-entry queue of run commands between the front and the back.
// ----------------------------------------------------------------------------
module erle_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  erle_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output erle_pkg::cmd_t head
);
  import erle_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill_count;

  assign full  = (fill_count == 2'd2);
  assign empty = (fill_count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fill_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill_count <= fill_count + 2'd1;
        2'b01:   fill_count <= fill_count - 2'd1;
        default: fill_count <= fill_count;
      endcase
    end
  end

endmodule

@@ design/erle_back.sv @@
// ----------------------------------------------------------------------------
// erle_back
// Splits each run at frame ends and drives the registered segment output.
// ----------------------------------------------------------------------------
module erle_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  erle_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output erle_pkg::out_t out_item
);
  import erle_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t              state;
  logic [POS_W-1:0]    pos;
  logic [COUNT_W-1:0]  rem;
  logic [7:0]          fill;
  logic [SEGNUM_W-1:0] seg_num;

  logic                out_free;
  logic [CALC_W-1:0]   room;
  logic [CALC_W-1:0]   seg;
  logic [CALC_W-1:0]   seg_end;
  logic                at_end;
  logic                seg_last;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    room     = CALC_W'(FRAME_BYTES) - CALC_W'(pos);
    seg      = (CALC_W'(rem) < room) ? CALC_W'(rem) : room;
    seg_end  = CALC_W'(pos) + seg;
    at_end   = (seg_end == CALC_W'(FRAME_BYTES));
    seg_last = (seg == CALC_W'(rem)) || (seg_num == SEGNUM_W'(MAX_RESULTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      seg_num   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
          if (!q_empty) begin
            if (q_head.restart) begin
              pos <= '0;
            end
            rem     <= q_head.count;
            fill    <= q_head.fill;
            seg_num <= '0;
            if (q_head.count != '0) begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_item.fill_byte   <= fill;
            out_item.start_index <= 10'(pos);
            out_item.byte_count  <= 11'(seg);
            out_item.frame_done  <= at_end;
            out_item.last        <= seg_last;
            pos                  <= at_end ? '0 : POS_W'(seg_end);
            rem                  <= rem - COUNT_W'(seg);
            seg_num              <= seg_num + SEGNUM_W'(1);
            // drop whatever is left once the segment limit is hit
            if (seg_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule
